@@ src/tvd_pkg.sv @@
package tvd_pkg;

	localparam int DATA_W = 32;
	localparam int NUM_LANES = 5;
	localparam int SUM_W = DATA_W + 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int DEN_W = 2 * DATA_W;
	localparam int NUM_W = 3 * DATA_W + 1;
	localparam int QUO_W = DATA_W + 1;
	localparam int LO_W = SUM_W / 2;
	localparam int HI_W = SUM_W - LO_W;
	// lane register stages: s1..s4, then one per quotient bit
	localparam int LANE_LAT = 4 + QUO_W;

	typedef enum logic [2:0] {
		LIM_MINMOD    = 3'd0,
		LIM_MC        = 3'd1,
		LIM_VANLEER   = 3'd2,
		LIM_SUPERBEE  = 3'd3,
		LIM_VANALBADA = 3'd4
	} lim_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] left_density;
		logic signed [DATA_W-1:0] right_density;
		logic signed [DATA_W-1:0] left_vel_x;
		logic signed [DATA_W-1:0] right_vel_x;
		logic signed [DATA_W-1:0] left_vel_y;
		logic signed [DATA_W-1:0] right_vel_y;
		logic signed [DATA_W-1:0] left_vel_z;
		logic signed [DATA_W-1:0] right_vel_z;
		logic signed [DATA_W-1:0] left_pressure;
		logic signed [DATA_W-1:0] right_pressure;
	} tvd_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] limited_density;
		logic signed [DATA_W-1:0] limited_vel_x;
		logic signed [DATA_W-1:0] limited_vel_y;
		logic signed [DATA_W-1:0] limited_vel_z;
		logic signed [DATA_W-1:0] limited_pressure;
	} tvd_out_t;

	// sideband that rides along the divider stages
	typedef struct packed {
		logic [SUM_W-1:0] simple_mag;
		logic             neg;
		logic             zero;
		logic             use_div;
	} lane_tag_t;

endpackage

@@ src/tvd_slope_limiter_top.sv @@
// TVD slope limiter, five components (density, x/y/z velocity, pressure) in
// parallel lanes. One cell per clock is accepted while the output is not
// stalled; a result passes through the lane stages and the output register.
// The per-lane restoring divider, used by van Leer and van Albada, resolves
// one quotient bit per pipeline stage. A cfg_wr_data write takes effect for
// items accepted after the write; codes 5 to 7 act as minmod.
module tvd_slope_limiter_top
	import tvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  tvd_in_t    in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output tvd_out_t   out_data
);

	logic [2:0] sel_q;
	logic       en;
	logic [LANE_LAT-1:0] vld_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= LIM_MINMOD;
		end else if (cfg_wr_en) begin
			sel_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LANE_LAT-2:0], in_valid};
			out_valid <= vld_q[LANE_LAT-1];
		end
	end

	logic signed [DATA_W-1:0] lft [NUM_LANES];
	logic signed [DATA_W-1:0] rgt [NUM_LANES];
	logic signed [DATA_W-1:0] res [NUM_LANES];

	always_comb begin
		lft[0] = in_data.left_density;   rgt[0] = in_data.right_density;
		lft[1] = in_data.left_vel_x;     rgt[1] = in_data.right_vel_x;
		lft[2] = in_data.left_vel_y;     rgt[2] = in_data.right_vel_y;
		lft[3] = in_data.left_vel_z;     rgt[3] = in_data.right_vel_z;
		lft[4] = in_data.left_pressure;  rgt[4] = in_data.right_pressure;
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		tvd_lane u_lane (
			.clk    (clk),
			.en     (en),
			.sel    (sel_q),
			.left   (lft[l]),
			.right  (rgt[l]),
			.result (res[l])
		);
	end

	// merge lane results into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.limited_density  <= res[0];
			out_data.limited_vel_x    <= res[1];
			out_data.limited_vel_y    <= res[2];
			out_data.limited_vel_z    <= res[3];
			out_data.limited_pressure <= res[4];
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !vld_q[LANE_LAT-1]) |=> !out_valid)
		else $error("result repeated after transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> $stable(vld_q))
		else $error("pipeline advanced while stalled");

endmodule

@@ src/tvd_div.sv @@
module tvd_div
	import tvd_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  lane_tag_t        tag_in,
	output logic [QUO_W-1:0] quo,
	output lane_tag_t        tag_out
);

	logic [NUM_W-1:0] r_s   [QUO_W];
	logic [DEN_W-1:0] d_s   [QUO_W];
	logic [QUO_W-1:0] q_s   [QUO_W];
	lane_tag_t        tag_s [QUO_W];

	// restoring division, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QUO_W; k++) begin : g_st
		localparam int SH = QUO_W - 1 - k;
		logic [NUM_W-1:0] r_in;
		logic [NUM_W-1:0] dsh;
		logic [DEN_W-1:0] d_in;
		logic [QUO_W-1:0] q_in;
		lane_tag_t        t_in;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign t_in = tag_in;
		end else begin : g_next
			assign r_in = r_s[k-1];
			assign d_in = d_s[k-1];
			assign q_in = q_s[k-1];
			assign t_in = tag_s[k-1];
		end

		assign dsh = NUM_W'(d_in) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (r_in >= dsh) begin
					r_s[k] <= r_in - dsh;
					q_s[k] <= {q_in[QUO_W-2:0], 1'b1};
				end else begin
					r_s[k] <= r_in;
					q_s[k] <= {q_in[QUO_W-2:0], 1'b0};
				end
				d_s[k]   <= d_in;
				tag_s[k] <= t_in;
			end
		end
	end

	assign quo     = q_s[QUO_W-1];
	assign tag_out = tag_s[QUO_W-1];

endmodule

@@ src/tvd_lane.sv @@
module tvd_lane
	import tvd_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic [2:0]               sel,
	input  logic signed [DATA_W-1:0] left,
	input  logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0] result
);

	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (DATA_W - 1);

	// s0: magnitudes and sign test
	logic              na, nb;
	logic [DATA_W-1:0] xa, yb;
	assign na = left[DATA_W-1];
	assign nb = right[DATA_W-1];
	assign xa = na ? DATA_W'(-left) : DATA_W'(left);
	assign yb = nb ? DATA_W'(-right) : DATA_W'(right);

	logic [DATA_W-1:0] x_s1, y_s1;
	logic              neg_s1, zero_s1;
	logic [2:0]        sel_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= xa;
			y_s1    <= yb;
			neg_s1  <= na;
			zero_s1 <= (xa == '0) || (yb == '0) || (na != nb);
			sel_s1  <= sel;
		end
	end

	// s1: limiters without a divide
	logic [SUM_W-1:0]  sum, mn, x2, y2, sb1, sb2, mc_mag, sb_mag, simple;
	logic [SUM_W:0]    x4, y4;
	always_comb begin
		sum    = SUM_W'(x_s1) + SUM_W'(y_s1);
		mn     = (x_s1 < y_s1) ? SUM_W'(x_s1) : SUM_W'(y_s1);
		x4     = {x_s1, 2'b00};
		y4     = {y_s1, 2'b00};
		mc_mag = ((SUM_W+1)'(sum) < x4 && (SUM_W+1)'(sum) < y4) ? (sum >> 1)
		                                                      : (mn << 1);
		x2     = {x_s1, 1'b0};
		y2     = {y_s1, 1'b0};
		sb1    = (x2 < SUM_W'(y_s1)) ? x2 : SUM_W'(y_s1);
		sb2    = (SUM_W'(x_s1) < y2) ? SUM_W'(x_s1) : y2;
		sb_mag = (sb1 > sb2) ? sb1 : sb2;
		if (sel_s1 == LIM_MC) begin
			simple = mc_mag;
		end else if (sel_s1 == LIM_SUPERBEE) begin
			simple = sb_mag;
		end else begin
			simple = mn;
		end
	end

	logic [PROD_W-1:0] p_s2, sx_s2, sy_s2;
	logic [SUM_W-1:0]  sum_s2, simple_s2;
	logic              neg_s2, zero_s2, use_div_s2, is_va_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2       <= PROD_W'(x_s1) * PROD_W'(y_s1);
			sx_s2      <= PROD_W'(x_s1) * PROD_W'(x_s1);
			sy_s2      <= PROD_W'(y_s1) * PROD_W'(y_s1);
			sum_s2     <= sum;
			simple_s2  <= simple;
			neg_s2     <= neg_s1;
			zero_s2    <= zero_s1;
			use_div_s2 <= (sel_s1 == LIM_VANLEER) || (sel_s1 == LIM_VANALBADA);
			is_va_s2   <= (sel_s1 == LIM_VANALBADA);
		end
	end

	// s2: xy*(x+y) as two partial products, and x*x + y*y
	logic [PROD_W+LO_W-1:0] plo_s3;
	logic [PROD_W+HI_W-1:0] phi_s3;
	logic [DEN_W-1:0]       den_s3;
	logic [PROD_W-1:0]      p_s3;
	logic [SUM_W-1:0]       sum_s3;
	lane_tag_t              tag_s3;
	logic                   is_va_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3   <= (PROD_W+LO_W)'(p_s2) * (PROD_W+LO_W)'(sum_s2[LO_W-1:0]);
			phi_s3   <= (PROD_W+HI_W)'(p_s2) * (PROD_W+HI_W)'(sum_s2[SUM_W-1:LO_W]);
			den_s3   <= sx_s2 + sy_s2;
			p_s3     <= p_s2;
			sum_s3   <= sum_s2;
			tag_s3   <= '{simple_mag: simple_s2, neg: neg_s2, zero: zero_s2,
			              use_div: use_div_s2};
			is_va_s3 <= is_va_s2;
		end
	end

	// s3: pick the dividend and divisor of the selected limiter
	logic [NUM_W-1:0] num_va, num_vl;
	assign num_va = NUM_W'(plo_s3) + (NUM_W'(phi_s3) << LO_W);
	assign num_vl = NUM_W'({p_s3, 1'b0});

	logic [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0] den_s4;
	lane_tag_t        tag_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= is_va_s3 ? num_va : num_vl;
			den_s4 <= is_va_s3 ? den_s3 : DEN_W'(sum_s3);
			tag_s4 <= tag_s3;
		end
	end

	logic [QUO_W-1:0] quo;
	lane_tag_t        tag_d;

	tvd_div u_div (
		.clk     (clk),
		.en      (en),
		.num     (num_s4),
		.den     (den_s4),
		.tag_in  (tag_s4),
		.quo     (quo),
		.tag_out (tag_d)
	);

	// sign and saturation
	logic [SUM_W-1:0] mag, msat;
	always_comb begin
		mag = tag_d.use_div ? quo : tag_d.simple_mag;
		if (tag_d.neg) begin
			msat = (mag > HALF) ? HALF : mag;
		end else begin
			msat = (mag > HALF - 1'b1) ? HALF - 1'b1 : mag;
		end
		if (tag_d.zero) begin
			result = '0;
		end else if (tag_d.neg) begin
			result = DATA_W'(-msat);
		end else begin
			result = DATA_W'(msat);
		end
	end

endmodule
